[design/lfct_pkg.sv]
// ----------------------------------------------------------------------------
// lfct_pkg
// shared types, register codes, reset values and pattern decode for the
// line follow corner tracker
// ----------------------------------------------------------------------------
package lfct_pkg;

    localparam int ENTRY_DEBOUNCE_DEF = 1;
    localparam int EXIT_DEBOUNCE_DEF  = 3;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        CORNER_NONE  = 2'd0,
        CORNER_LEFT  = 2'd1,
        CORNER_RIGHT = 2'd2
    } t_corner;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_SPEED    = 4'd0,
        REG_LINE_SETPOINT = 4'd1,
        REG_LAPS_TO_STOP  = 4'd2,
        REG_STEER_GAIN    = 4'd3,
        REG_STEER_LIMIT   = 4'd4,
        REG_CORNER_SPEED  = 4'd5,
        REG_SLEW_STEP     = 4'd6,
        REG_HOLD_TICKS    = 4'd7
    } t_reg_idx;

    localparam logic signed [10:0] BASE_SPEED_RST    = 11'sd25;
    localparam logic signed [15:0] LINE_SETPOINT_RST = 16'sd0;
    localparam logic [7:0]         LAPS_TO_STOP_RST  = 8'd0;
    localparam logic [9:0]         STEER_GAIN_RST    = 10'd45;
    localparam logic [9:0]         STEER_LIMIT_RST   = 10'd500;
    localparam logic [9:0]         CORNER_SPEED_RST  = 10'd30;
    localparam logic [7:0]         SLEW_STEP_RST     = 8'd20;
    localparam logic [7:0]         HOLD_TICKS_RST    = 8'd8;

    // left checked first
    function automatic t_corner f_classify(input logic [7:0] s);
        t_corner res;
        if ((s[0] && s[1] && s[2] && s[3] && !s[5] && !s[6] && !s[7]) || (s[0] && s[1])) begin
            res = CORNER_LEFT;
        end else if ((s[4] && s[5] && s[6] && s[7] && !s[0] && !s[1] && !s[2])
                     || (s[6] && s[7])) begin
            res = CORNER_RIGHT;
        end else begin
            res = CORNER_NONE;
        end
        return res;
    endfunction

endpackage

[design/line_follow_corner_tracker.sv]
// ----------------------------------------------------------------------------
// line_follow_corner_tracker
// wheel target generation for a line follower with debounced corner turns
// ----------------------------------------------------------------------------
// usage
//   input channel: one beat per control tick (sensor bits, line weight),
//   valid/ready. output channel: one beat per input beat with both wheel
//   targets, turn value, corner state, stop flag and corner count.
//   config channel: register index and data, always ready; a write to a
//   known index stores the value and restarts the tracker. the user must
//   make writes only while no beat is in flight; not enforced by the block.
//   a beat accepted passes the input register, then the result register,
//   on its way to the output. throughput: one beat per cycle while the
//   receiver takes results; the steering multiply feeds the input register
//   and the corner state update plus slew limit feed the result register.
//   the input side keeps accepting while a result waits, if the input
//   register is empty or empties into the result register that same cycle.
//   reset: synchronous, registers return to their reset values, tracker
//   state cleared, both channels empty. when the receiver stalls, the
//   result holds and the input register fills, then o_in_ready drops.
// ----------------------------------------------------------------------------
module line_follow_corner_tracker #(
    parameter int ENTRY_DEBOUNCE = lfct_pkg::ENTRY_DEBOUNCE_DEF,
    parameter int EXIT_DEBOUNCE  = lfct_pkg::EXIT_DEBOUNCE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lfct_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lfct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_sensor_bits,
    input  logic signed [15:0]              i_line_weight,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [11:0]              o_left_target,
    output logic signed [11:0]              o_right_target,
    output logic signed [10:0]              o_turn_value,
    output logic [1:0]                      o_corner_now,
    output logic                            o_stopped,
    output logic [15:0]                     o_corners_passed
);
    import lfct_pkg::*;

    // configuration
    logic signed [10:0] r_base_speed;
    logic signed [15:0] r_line_setpoint;
    logic [7:0]         r_laps_to_stop;
    logic [9:0]         r_steer_gain;
    logic [9:0]         r_steer_limit;
    logic [9:0]         r_corner_speed;
    logic [7:0]         r_slew_step;
    logic [7:0]         r_hold_ticks;

    // tracker state
    t_corner            r_mode, n_mode;
    t_corner            r_cand, n_cand;
    logic [CNT_W-1:0]   r_entry, n_entry;
    logic [CNT_W-1:0]   r_hold_left, n_hold_left;
    logic [CNT_W-1:0]   r_exit, n_exit;
    logic [15:0]        r_pass_count, n_pass_count;
    logic signed [11:0] r_prev_left, n_prev_left;
    logic signed [11:0] r_prev_right, n_prev_right;
    logic               r_halted, n_halted;

    // input register
    logic               r_in_valid;
    logic [7:0]         r_sensor_bits;
    logic signed [10:0] r_follow_turn;
    logic signed [10:0] n_follow_turn;

    // result register
    logic               r_out_valid;
    logic signed [11:0] r_left_target;
    logic signed [11:0] r_right_target;
    logic signed [10:0] r_turn_value;
    logic [1:0]         r_corner_now;
    logic               r_stopped;
    logic [15:0]        r_corners_passed;

    logic signed [10:0] n_turn_value;
    logic               n_stopped;

    logic cfg_we;
    logic in_accept;
    logic advance;

    logic signed [16:0] err;
    logic signed [27:0] prod;
    logic signed [27:0] prod_adj;
    logic signed [27:0] trunc;
    logic signed [27:0] lim;

    t_corner            det;
    logic               all_off;
    logic               halt_fire;
    logic signed [11:0] follow_left;
    logic signed [11:0] follow_right;

    function automatic logic signed [11:0] f_slew(
        input logic signed [11:0] target,
        input logic signed [11:0] last,
        input logic [7:0]         step
    );
        logic signed [12:0] diff;
        logic signed [12:0] st;
        logic signed [12:0] sum;
        diff = {target[11], target} - {last[11], last};
        st   = {5'b0, step};
        if (diff > st) begin
            diff = st;
        end else if (diff < -st) begin
            diff = -st;
        end
        sum = {last[11], last} + diff;
        if (step == 8'd0) begin
            sum = {target[11], target};
        end
        return sum[11:0];
    endfunction

    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_accept   = i_in_valid && o_in_ready;

    // proportional term, truncated toward zero and clamped
    always_comb begin
        err      = {r_line_setpoint[15], r_line_setpoint} - {i_line_weight[15], i_line_weight};
        prod     = err * $signed({1'b0, r_steer_gain});
        prod_adj = prod + (prod[27] ? 28'sd255 : 28'sd0);
        trunc    = prod_adj >>> 8;
        lim      = $signed({18'b0, r_steer_limit});
        if (trunc > lim) begin
            trunc = lim;
        end else if (trunc < -lim) begin
            trunc = -lim;
        end
        n_follow_turn = trunc[10:0];
    end

    // corner tracking and wheel targets
    always_comb begin
        det       = f_classify(r_sensor_bits);
        all_off   = (r_sensor_bits == 8'd0);
        halt_fire = !r_halted && (r_laps_to_stop != 8'd0)
                    && (r_pass_count >= {6'b0, r_laps_to_stop, 2'b00});

        n_mode       = r_mode;
        n_cand       = r_cand;
        n_entry      = r_entry;
        n_hold_left  = r_hold_left;
        n_exit       = r_exit;
        n_pass_count = r_pass_count;
        n_halted     = r_halted;
        n_stopped    = 1'b0;

        follow_left  = f_slew({r_base_speed[10], r_base_speed} + {r_follow_turn[10], r_follow_turn},
                              r_prev_left, r_slew_step);
        follow_right = f_slew({r_base_speed[10], r_base_speed} - {r_follow_turn[10], r_follow_turn},
                              r_prev_right, r_slew_step);

        if (r_halted || halt_fire) begin
            n_mode       = CORNER_NONE;
            n_cand       = CORNER_NONE;
            n_entry      = '0;
            n_hold_left  = '0;
            n_exit       = '0;
            n_pass_count = '0;
            n_halted     = 1'b1;
            n_stopped    = 1'b1;
        end else if (r_mode == CORNER_NONE) begin
            n_exit = '0;
            if (det != CORNER_NONE || (all_off && r_cand != CORNER_NONE)) begin
                if (det != CORNER_NONE && r_cand != det) begin
                    n_cand  = det;
                    n_entry = 8'd1;
                end else if (r_entry < CNT_MAX) begin
                    n_entry = r_entry + 8'd1;
                end
                if (n_entry >= 8'(ENTRY_DEBOUNCE)) begin
                    n_mode       = n_cand;
                    n_pass_count = r_pass_count + 16'd1;
                    n_cand       = CORNER_NONE;
                    n_entry      = '0;
                    n_hold_left  = r_hold_ticks;
                    n_exit       = '0;
                end
            end else begin
                n_cand  = CORNER_NONE;
                n_entry = '0;
            end
        end else begin
            n_cand  = CORNER_NONE;
            n_entry = '0;
            if (r_hold_left != '0) begin
                n_hold_left = r_hold_left - 8'd1;
                n_exit      = '0;
            end else if (det == r_mode || all_off) begin
                n_exit = '0;
            end else begin
                if (r_exit < CNT_MAX) begin
                    n_exit = r_exit + 8'd1;
                end
                if (n_exit >= 8'(EXIT_DEBOUNCE)) begin
                    n_mode = CORNER_NONE;
                    n_exit = '0;
                end
            end
        end

        if (n_halted) begin
            n_prev_left  = '0;
            n_prev_right = '0;
            n_turn_value = '0;
        end else if (n_mode == CORNER_LEFT) begin
            n_prev_left  = '0;
            n_prev_right = {2'b0, r_corner_speed};
            n_turn_value = {1'b0, r_corner_speed};
        end else if (n_mode == CORNER_RIGHT) begin
            n_prev_left  = {2'b0, r_corner_speed};
            n_prev_right = '0;
            n_turn_value = -$signed({1'b0, r_corner_speed});
        end else begin
            n_prev_left  = follow_left;
            n_prev_right = follow_right;
            n_turn_value = r_follow_turn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_speed    <= BASE_SPEED_RST;
            r_line_setpoint <= LINE_SETPOINT_RST;
            r_laps_to_stop  <= LAPS_TO_STOP_RST;
            r_steer_gain    <= STEER_GAIN_RST;
            r_steer_limit   <= STEER_LIMIT_RST;
            r_corner_speed  <= CORNER_SPEED_RST;
            r_slew_step     <= SLEW_STEP_RST;
            r_hold_ticks    <= HOLD_TICKS_RST;
            r_mode          <= CORNER_NONE;
            r_cand          <= CORNER_NONE;
            r_entry         <= '0;
            r_hold_left     <= '0;
            r_exit          <= '0;
            r_pass_count    <= '0;
            r_prev_left     <= '0;
            r_prev_right    <= '0;
            r_halted        <= 1'b0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (cfg_we && i_cfg_index <= REG_HOLD_TICKS) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_BASE_SPEED:    r_base_speed    <= i_cfg_data[10:0];
                    REG_LINE_SETPOINT: r_line_setpoint <= i_cfg_data[15:0];
                    REG_LAPS_TO_STOP:  r_laps_to_stop  <= i_cfg_data[7:0];
                    REG_STEER_GAIN:    r_steer_gain    <= i_cfg_data[9:0];
                    REG_STEER_LIMIT:   r_steer_limit   <= i_cfg_data[9:0];
                    REG_CORNER_SPEED:  r_corner_speed  <= i_cfg_data[9:0];
                    REG_SLEW_STEP:     r_slew_step     <= i_cfg_data[7:0];
                    REG_HOLD_TICKS:    r_hold_ticks    <= i_cfg_data[7:0];
                    default: ;
                endcase
                r_mode       <= CORNER_NONE;
                r_cand       <= CORNER_NONE;
                r_entry      <= '0;
                r_hold_left  <= '0;
                r_exit       <= '0;
                r_pass_count <= '0;
                r_prev_left  <= '0;
                r_prev_right <= '0;
                r_halted     <= 1'b0;
            end else if (advance) begin
                r_mode       <= n_mode;
                r_cand       <= n_cand;
                r_entry      <= n_entry;
                r_hold_left  <= n_hold_left;
                r_exit       <= n_exit;
                r_pass_count <= n_pass_count;
                r_prev_left  <= n_prev_left;
                r_prev_right <= n_prev_right;
                r_halted     <= n_halted;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sensor_bits <= i_sensor_bits;
            r_follow_turn <= n_follow_turn;
        end
        if (advance) begin
            r_left_target    <= n_prev_left;
            r_right_target   <= n_prev_right;
            r_turn_value     <= n_turn_value;
            r_corner_now     <= n_mode;
            r_stopped        <= n_stopped;
            r_corners_passed <= n_pass_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_left_target    = r_left_target;
    assign o_right_target   = r_right_target;
    assign o_turn_value     = r_turn_value;
    assign o_corner_now     = r_corner_now;
    assign o_stopped        = r_stopped;
    assign o_corners_passed = r_corners_passed;

`ifndef NO_ASSERTIONS
    a_hold_only_in_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_left != '0 |-> r_mode != CORNER_NONE)
        else $error("hold counter running outside a corner");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted && !cfg_we |=> r_halted)
        else $error("halt released without a config write");

    a_entry_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !cfg_we && !r_halted && !halt_fire && r_mode == CORNER_NONE
        && n_mode != CORNER_NONE |=> r_pass_count == $past(r_pass_count) + 16'd1)
        else $error("corner entry not counted");

    a_stopped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_stopped |-> r_left_target == '0 && r_right_target == '0
        && r_corner_now == CORNER_NONE && r_corners_passed == '0)
        else $error("stopped beat carries nonzero payload");

    a_left_inner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_corner_now == CORNER_LEFT |-> r_left_target == '0
        && r_right_target == $signed({2'b0, r_corner_speed}))
        else $error("left corner targets wrong");
`endif

endmodule
